### hdl/slot_table_with_sort_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the slot table with sort
// Implication checks sampled on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SLOT_TABLE_WITH_SORT_ASSERT_SVH
`define SLOT_TABLE_WITH_SORT_ASSERT_SVH

// same-cycle implication
`define STS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define STS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### hdl/sts_pkg.sv
// ---------------------------------------------------------------------------
// Slot table package
// Sizes, codes, entry layout and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
package sts_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ID_W  = 31;
  localparam int ACT_W = 7;

  localparam logic [ACT_W-1:0] ACTIVE_RST = 7'd64;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_REMOVE   = 3'd1;
  localparam logic [2:0] CMD_LOOKUP   = 3'd2;
  localparam logic [2:0] CMD_SORT_ASC = 3'd3;
  localparam logic [2:0] CMD_SORT_DSC = 3'd4;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_OCC  = 2'd1;
  localparam logic [1:0] ST_DEL  = 2'd2;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_FULL     = 2'd1;
  localparam logic [1:0] RES_NOTFOUND = 2'd2;
  localparam logic [1:0] RES_ZERO     = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [1:0]      st;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       rd_next;
    logic       ld_cur;
    logic       hit_wr;
    logic       step;
    logic       cmp;
    logic       wr_last;
    logic       new_pass;
    logic       emit;
    logic [1:0] res;
  } dp_ctrl_t;

  typedef struct packed {
    logic       n_zero;
    logic       n_small;
    logic       hit;
    logic       scan_last;
    logic       cmp_last;
    logic       swapped;
    logic       lim_gt1;
    logic [2:0] cmd;
  } dp_stat_t;

endpackage

### hdl/sts_ctrl.sv
// ---------------------------------------------------------------------------
// Slot table controller
// Sequences slot scans and bubble-sort passes over the datapath.
// ---------------------------------------------------------------------------
module sts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [2:0]       cmd_i,
  input  sts_pkg::dp_stat_t stat_i,
  output sts_pkg::dp_ctrl_t ctrl_o,
  output logic             busy
);
  import sts_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_CK = 3'd2;
  localparam logic [2:0] S_SORT_R0 = 3'd3;
  localparam logic [2:0] S_SORT_L0 = 3'd4;
  localparam logic [2:0] S_SORT_RD = 3'd5;
  localparam logic [2:0] S_SORT_CP = 3'd6;
  localparam logic [2:0] S_SORT_EN = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (cmd_i) inside
            CMD_INSERT, CMD_REMOVE, CMD_LOOKUP: begin
              if (stat_i.n_zero) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.res  = (cmd_i == CMD_INSERT) ? RES_FULL : RES_NOTFOUND;
              end else begin
                ctrl_o.load = 1'b1;
                state_d     = S_SCAN_RD;
              end
            end
            CMD_SORT_ASC, CMD_SORT_DSC: begin
              if (stat_i.n_small) begin
                ctrl_o.emit = 1'b1;
                ctrl_o.res  = RES_ZERO;
              end else begin
                ctrl_o.load = 1'b1;
                state_d     = S_SORT_R0;
              end
            end
            default: begin
              ctrl_o.emit = 1'b1;
              ctrl_o.res  = RES_ZERO;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (stat_i.hit) begin
          ctrl_o.hit_wr = 1'b1;
          ctrl_o.emit   = 1'b1;
          ctrl_o.res    = RES_OK;
          state_d       = S_IDLE;
        end else if (stat_i.scan_last) begin
          ctrl_o.emit = 1'b1;
          ctrl_o.res  = (stat_i.cmd == CMD_INSERT) ? RES_FULL : RES_NOTFOUND;
          state_d     = S_IDLE;
        end else begin
          ctrl_o.step = 1'b1;
          state_d     = S_SCAN_RD;
        end
      end
      S_SORT_R0: begin
        state_d = S_SORT_L0;
      end
      S_SORT_L0: begin
        ctrl_o.ld_cur = 1'b1;
        state_d       = S_SORT_RD;
      end
      S_SORT_RD: begin
        ctrl_o.rd_next = 1'b1;
        state_d        = S_SORT_CP;
      end
      S_SORT_CP: begin
        ctrl_o.cmp = 1'b1;
        state_d    = stat_i.cmp_last ? S_SORT_EN : S_SORT_RD;
      end
      S_SORT_EN: begin
        ctrl_o.wr_last = 1'b1;
        if (stat_i.swapped && stat_i.lim_gt1) begin
          ctrl_o.new_pass = 1'b1;
          state_d         = S_SORT_R0;
        end else begin
          ctrl_o.emit = 1'b1;
          ctrl_o.res  = RES_ZERO;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

### hdl/sts_datapath.sv
// ---------------------------------------------------------------------------
// Slot table datapath
// Slot memory with per-slot valid flags, scan and sort registers, result beat.
// ---------------------------------------------------------------------------
module sts_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sts_pkg::ACT_W-1:0]       cfg_wdata_i,
  input  logic [2:0]                      cmd_i,
  input  logic [sts_pkg::ID_W-1:0]        id_i,
  input  sts_pkg::dp_ctrl_t               ctrl_i,
  output sts_pkg::dp_stat_t               stat_o,
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [5:0]                      slot_index_o,
  output logic [sts_pkg::ID_W-1:0]        stored_id_o
);
  import sts_pkg::*;

  entry_t             mem [SLOTS];
  logic [SLOTS-1:0]   valid_q;
  entry_t             rd_q;
  logic               rv_q;

  logic [ACT_W-1:0]   active_q;
  logic [2:0]         cmd_q;
  logic [ID_W-1:0]    key_q;
  logic [IDX_W-1:0]   idx_q;
  logic [IDX_W-1:0]   lim_q;
  entry_t             cur_q;
  logic               swp_q;

  logic               res_valid_q;
  logic [1:0]         status_q;
  logic [5:0]         index_q;
  logic [ID_W-1:0]    stored_q;

  logic [CNT_W-1:0]   n_used;
  entry_t             entry;
  logic [ID_W-1:0]    ins_id;
  logic               hit;
  logic               ooo;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;

  always_comb begin
    if (32'(active_q) > SLOTS) begin
      n_used = CNT_W'(SLOTS);
    end else begin
      n_used = CNT_W'(active_q);
    end
  end

  assign entry  = rv_q ? rd_q : '0;
  assign ins_id = (&key_q) ? key_q : key_q + ID_W'(1);

  always_comb begin
    case (cmd_q) inside
      CMD_INSERT: hit = (entry.st == ST_FREE);
      CMD_REMOVE,
      CMD_LOOKUP: hit = (entry.st == ST_OCC) && (entry.id == key_q);
      default:    hit = 1'b0;
    endcase
  end

  assign ooo = (cmd_q == CMD_SORT_DSC) ? (cur_q.id < entry.id) : (cur_q.id > entry.id);

  assign raddr = ctrl_i.rd_next ? idx_q + IDX_W'(1) : idx_q;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = cur_q;
    if (ctrl_i.cmp) begin
      we    = 1'b1;
      wdata = ooo ? entry : cur_q;
    end else if (ctrl_i.wr_last) begin
      we    = 1'b1;
    end else if (ctrl_i.hit_wr && (cmd_q != CMD_LOOKUP)) begin
      we    = 1'b1;
      wdata = (cmd_q == CMD_INSERT) ? entry_t'{id: ins_id, st: ST_OCC}
                                    : entry_t'{id: entry.id, st: ST_DEL};
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // an unwritten slot reads as id zero, free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      rv_q <= valid_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ACTIVE_RST;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      res_valid_q <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      key_q <= id_i;
      idx_q <= '0;
      lim_q <= IDX_W'(n_used - CNT_W'(1));
      swp_q <= 1'b0;
    end else if (ctrl_i.new_pass) begin
      idx_q <= '0;
      lim_q <= lim_q - IDX_W'(1);
      swp_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      idx_q <= idx_q + IDX_W'(1);
      swp_q <= swp_q | ooo;
      if (!ooo) begin
        cur_q <= entry;
      end
    end else if (ctrl_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (ctrl_i.ld_cur) begin
      cur_q <= entry;
    end
    if (ctrl_i.emit) begin
      case (ctrl_i.res)
        RES_OK: begin
          status_q <= STATUS_DONE;
          index_q  <= 6'(idx_q);
          stored_q <= (cmd_q == CMD_INSERT) ? ins_id : key_q;
        end
        RES_FULL: begin
          status_q <= STATUS_FULL;
          index_q  <= '0;
          stored_q <= '0;
        end
        RES_NOTFOUND: begin
          status_q <= STATUS_NOTFOUND;
          index_q  <= '0;
          stored_q <= '0;
        end
        default: begin
          status_q <= STATUS_DONE;
          index_q  <= '0;
          stored_q <= '0;
        end
      endcase
    end
  end

  assign stat_o.n_zero    = (n_used == '0);
  assign stat_o.n_small   = (n_used <= CNT_W'(1));
  assign stat_o.hit       = hit;
  assign stat_o.scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == n_used);
  assign stat_o.cmp_last  = ((idx_q + IDX_W'(1)) == lim_q);
  assign stat_o.swapped   = swp_q;
  assign stat_o.lim_gt1   = (lim_q > IDX_W'(1));
  assign stat_o.cmd       = cmd_q;

  assign done_o       = res_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = index_q;
  assign stored_id_o  = stored_q;

endmodule

### hdl/slot_table_with_sort.sv
// ---------------------------------------------------------------------------
// Slot table with sort
// Insert/remove/lookup read, then check, each of up to n slots until a hit or the last.
// A sort pass over limit L compares neighbours; passes repeat until no swap or L is 1.
// Empty table, one-slot sort and unknown commands give a result beat in the next cycle.
// One command at a time; the next start is taken in the cycle its result shows.
// Reset: slots read as free with id zero at once via per-slot flags; active_slots 64.
// ---------------------------------------------------------------------------
`include "slot_table_with_sort_assert.svh"

module slot_table_with_sort (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sts_pkg::ACT_W-1:0] cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                cmd_i,
  input  logic [sts_pkg::ID_W-1:0]  id_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [5:0]                slot_index_o,
  output logic [sts_pkg::ID_W-1:0]  stored_id_o
);
  import sts_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  sts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy   (busy)
  );

  sts_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd_i),
    .id_i         (id_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .stored_id_o  (stored_id_o)
  );

  `STS_ASSERT_NXT(a_accept_moves, start && !busy, busy || done_o, "accepted beat went nowhere")
  `STS_ASSERT_IMP(a_end_gives_beat, $fell(busy), done_o, "command ended without a result")
  `STS_ASSERT_IMP(a_fail_zero, done_o && (status_o != STATUS_DONE),
                  (slot_index_o == '0) && (stored_id_o == '0), "failed result not zeroed")

endmodule
